@@ rtl/core/pcbv_pkg.sv @@
package pcbv_pkg;

   localparam int GRID_X = 256;
   localparam int GRID_Y = 256;
   localparam int GRID_Z = 8;
   localparam int NCELLS = GRID_X * GRID_Y;
   localparam int NVOX = NCELLS * GRID_Z;
   localparam int CELL_W = $clog2(NCELLS);
   localparam int VOX_W = $clog2(NVOX);
   localparam int QW = 17;

   localparam logic [1:0] MODE_INSERT = 2'd0;
   localparam logic [1:0] MODE_READ = 2'd1;
   localparam logic [1:0] MODE_CLEAR = 2'd2;

   localparam logic [2:0] CSR_MIN_X = 3'd0;
   localparam logic [2:0] CSR_MIN_Y = 3'd1;
   localparam logic [2:0] CSR_MIN_Z = 3'd2;
   localparam logic [2:0] CSR_SIZE_X = 3'd3;
   localparam logic [2:0] CSR_SIZE_Y = 3'd4;
   localparam logic [2:0] CSR_SIZE_Z = 3'd5;

   typedef enum logic [3:0] {
      ST_SWEEP, ST_IDLE, ST_DIV, ST_DIVWAIT, ST_RD, ST_RDWAIT, ST_UPD, ST_OUT, ST_CLEAR
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic       latch;
      logic       sweep;
      logic       div_start;
      logic [1:0] div_axis;
      logic       div_take;
      logic       mem_rd;
      logic       mem_wr;
      logic       emit;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       sweep_done;
      logic       div_done;
      logic [1:0] mode;
      logic       reject;
   } stat_type;

endpackage

@@ rtl/core/pcbv_div.sv @@
module pcbv_div import pcbv_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [QW-1:0] dividend,
   input  logic [14:0]   divisor,
   output logic [QW-1:0] quotient,
   output logic          done
);
   // restoring division, one quotient bit a cycle
   logic [QW-1:0] q_ff, q_in;
   logic [15:0]   r_ff, r_in;
   logic [4:0]    cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;
   logic [15:0]   trial;

   always_comb begin
      q_in = q_ff; r_in = r_ff; cnt_in = cnt_ff; busy_in = busy_ff; done_in = 1'b0;
      trial = {r_ff[14:0], q_ff[QW-1]};
      if (start) begin
         q_in = dividend; r_in = '0; cnt_in = 5'(QW); busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, divisor}) begin
            r_in = trial - {1'b0, divisor};
            q_in = {q_ff[QW-2:0], 1'b1};
         end else begin
            r_in = trial;
            q_in = {q_ff[QW-2:0], 1'b0};
         end
         cnt_in = cnt_ff - 5'd1;
         if (cnt_ff == 5'd1) begin
            busy_in = 1'b0; done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in; r_ff <= r_in; cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0; done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in; done_ff <= done_in;
      end
   end

   assign quotient = q_ff;
   assign done = done_ff;
endmodule

@@ rtl/core/pcbv_ctrl.sv @@
module pcbv_ctrl import pcbv_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  stat_type stat,
   output cmd_type  cmd
);
   state_type state_ff, state_in;
   logic [1:0] axis_ff, axis_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_SWEEP; axis_ff <= '0;
      end else begin
         state_ff <= state_in; axis_ff <= axis_in;
      end
   end

   always_comb begin
      state_in = state_ff; axis_in = axis_ff; cmd = '0; busy = 1'b1;
      cmd.div_axis = axis_ff;
      unique case (state_ff)
         ST_SWEEP: begin
            cmd.sweep = 1'b1;
            if (stat.sweep_done) state_in = ST_IDLE;
         end
         ST_CLEAR: begin
            // clear request: sweep, then answer
            cmd.sweep = 1'b1;
            if (stat.sweep_done) state_in = ST_OUT;
         end
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.latch = 1'b1; axis_in = 2'd0; state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            priority if (stat.mode == MODE_CLEAR) state_in = ST_CLEAR;
            else if (stat.mode == MODE_READ) state_in = ST_RD;
            else if (stat.mode != MODE_INSERT) state_in = ST_OUT;
            else begin
               cmd.div_start = 1'b1; state_in = ST_DIVWAIT;
            end
         end
         ST_DIVWAIT: begin
            if (stat.div_done) begin
               cmd.div_take = 1'b1;
               if (axis_ff == 2'd2) state_in = ST_RD;
               else begin
                  axis_in = axis_ff + 2'd1; state_in = ST_DIV;
               end
            end
         end
         ST_RD: begin
            if (stat.reject) state_in = ST_OUT;
            else begin
               cmd.mem_rd = 1'b1; state_in = ST_RDWAIT;
            end
         end
         ST_RDWAIT: state_in = (stat.mode == MODE_READ) ? ST_OUT : ST_UPD;
         ST_UPD: begin
            cmd.mem_wr = 1'b1; state_in = ST_OUT;
         end
         ST_OUT: begin
            cmd.emit = 1'b1; state_in = ST_IDLE;
         end
         default: state_in = ST_SWEEP;
      endcase
   end
endmodule

@@ rtl/core/pcbv_dp.sv @@
module pcbv_dp import pcbv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   output stat_type           stat,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic [7:0]         req_intensity,
   input  logic [7:0]         req_read_cell_y,
   input  logic [7:0]         req_read_cell_x,
   output logic               rsp_strobe,
   output logic signed [3:0]  rsp_coor_z,
   output logic signed [8:0]  rsp_coor_y,
   output logic signed [8:0]  rsp_coor_x,
   output logic signed [19:0] rsp_voxel_number,
   output logic signed [15:0] rsp_cell_max_height,
   output logic signed [31:0] rsp_cell_height_sum,
   output logic [7:0]         rsp_cell_max_intensity,
   output logic [23:0]        rsp_cell_intensity_sum,
   output logic [15:0]        rsp_cell_point_count,
   output logic               rsp_cell_occupied,
   output logic [9:0]         rsp_cell_height_bins
);
   localparam int XW = $clog2(GRID_X);
   localparam int YW = $clog2(GRID_Y);
   localparam int ZW = $clog2(GRID_Z);
   localparam int CW = 107; // packed cell record width

   logic signed [15:0] minx_ff, miny_ff, minz_ff;
   logic [14:0] szx_ff, szy_ff, szz_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         minx_ff <= 16'sd0; miny_ff <= -16'sd4096; minz_ff <= -16'sd300;
         szx_ff <= 15'd32; szy_ff <= 15'd32; szz_ff <= 15'd100;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MIN_X: minx_ff <= csr_data;
            CSR_MIN_Y: miny_ff <= csr_data;
            CSR_MIN_Z: minz_ff <= csr_data;
            CSR_SIZE_X: szx_ff <= csr_data[14:0];
            CSR_SIZE_Y: szy_ff <= csr_data[14:0];
            CSR_SIZE_Z: szz_ff <= csr_data[14:0];
            default: ;
         endcase
      end
   end

   // latched request
   logic [1:0] mode_ff;
   logic signed [15:0] px_ff, py_ff, pz_ff;
   logic [7:0] int_ff, ry_ff, rx_ff;
   always_ff @(posedge clock) begin
      if (cmd.latch) begin
         mode_ff <= req_mode; px_ff <= req_point_x; py_ff <= req_point_y;
         pz_ff <= req_point_z; int_ff <= req_intensity;
         ry_ff <= req_read_cell_y; rx_ff <= req_read_cell_x;
      end
   end

   // axis offsets and divider
   logic signed [16:0] d_sel;
   logic [14:0] s_sel;
   logic [QW-1:0] quo;
   logic div_done;
   always_comb begin
      unique case (cmd.div_axis)
         2'd0: begin d_sel = 17'(px_ff) - 17'(minx_ff); s_sel = szx_ff; end
         2'd1: begin d_sel = 17'(py_ff) - 17'(miny_ff); s_sel = szy_ff; end
         default: begin d_sel = 17'(pz_ff) - 17'(minz_ff); s_sel = szz_ff; end
      endcase
   end

   pcbv_div u_div (.clock, .reset, .start(cmd.div_start), .dividend(d_sel),
      .divisor(s_sel), .quotient(quo), .done(div_done));

   logic [2:0] bad_ff, bad_in;
   logic [XW-1:0] cx_ff;
   logic [YW-1:0] cy_ff;
   logic [ZW-1:0] cz_ff;
   logic [16:0] grid_lim;
   logic ax_bad;
   always_comb begin
      unique case (cmd.div_axis)
         2'd0: grid_lim = 17'(GRID_X);
         2'd1: grid_lim = 17'(GRID_Y);
         default: grid_lim = 17'(GRID_Z);
      endcase
      ax_bad = (s_sel == '0) || d_sel[16] || (quo >= grid_lim);
      bad_in = bad_ff;
      if (cmd.latch) bad_in = '0;
      else if (cmd.div_take) bad_in[cmd.div_axis] = ax_bad;
   end
   always_ff @(posedge clock) begin
      bad_ff <= bad_in;
      if (cmd.div_take) begin
         unique case (cmd.div_axis)
            2'd0: cx_ff <= quo[XW-1:0];
            2'd1: cy_ff <= quo[YW-1:0];
            default: cz_ff <= quo[ZW-1:0];
         endcase
      end
   end

   logic rd_oob;
   assign rd_oob = (mode_ff == MODE_READ) &&
      ((9'(ry_ff) >= 9'(GRID_Y)) || (9'(rx_ff) >= 9'(GRID_X)));
   wire reject = (mode_ff == MODE_INSERT) ? (bad_ff != 3'd0) : rd_oob;

   // sweep counter clears both memories
   logic [VOX_W:0] sw_ff;
   always_ff @(posedge clock) begin
      if (reset || !cmd.sweep) sw_ff <= '0;
      else sw_ff <= sw_ff + 1'b1;
   end
   wire sweep_done = cmd.sweep && (sw_ff == (VOX_W+1)'(NVOX - 1));

   logic [CELL_W-1:0] cell_addr;
   logic [VOX_W-1:0] vi;
   always_comb begin
      if (mode_ff == MODE_READ)
         cell_addr = CELL_W'(32'(ry_ff) * GRID_X + 32'(rx_ff));
      else
         cell_addr = CELL_W'(32'(cy_ff) * GRID_X + 32'(cx_ff));
      vi = VOX_W'(32'(cz_ff) * NCELLS + 32'(cell_addr));
   end

   // voxel table: valid bit plus number
   logic [20:0] vox_mem [NVOX];
   logic [20:0] vox_rd_ff;
   logic [CW-1:0] cell_mem [NCELLS];
   logic [CW-1:0] cell_rd_ff;
   logic [19:0] vcnt_ff;

   logic [20:0] vox_wd;
   logic [CW-1:0] cell_wd;
   logic [19:0] num;
   logic signed [15:0] mh; logic signed [31:0] hs; logic [7:0] mi;
   logic [23:0] is; logic [15:0] cn; logic oc; logic [9:0] hb;
   logic signed [32:0] hs_sum; logic [24:0] is_sum;
   logic signed [16:0] bz; logic [3:0] bin;

   always_comb begin
      {mh, hs, mi, is, cn, oc, hb} = cell_rd_ff;
      num = vox_rd_ff[19:0];
      vox_wd = vox_rd_ff;
      if (!vox_rd_ff[20]) begin
         vox_wd = {1'b1, vcnt_ff}; num = vcnt_ff; mh = pz_ff; mi = int_ff;
      end else if (pz_ff > mh) begin
         mh = pz_ff; mi = int_ff;
      end
      hs_sum = 33'(hs) + 33'(pz_ff);
      if (hs_sum > 33'sd2147483647) hs = 32'h7fffffff;
      else if (hs_sum < -33'sd2147483648) hs = 32'h80000000;
      else hs = hs_sum[31:0];
      is_sum = 25'(is) + 25'(int_ff);
      is = is_sum[24] ? 24'hffffff : is_sum[23:0];
      if (cn != 16'hffff) cn = cn + 16'd1;
      oc = 1'b1;
      bz = 17'(pz_ff) + 17'sd300;
      if (bz < 0) bin = 4'd0;
      else if (bz >= 17'sd450) bin = 4'd9;
      else bin = 4'((15'(bz[8:0]) * 15'd41) >> 11); // /50 for values under 450
      hb = hb | (10'd1 << bin);
      cell_wd = {mh, hs, mi, is, cn, oc, hb};
   end

   always_ff @(posedge clock) begin
      if (cmd.sweep) vox_mem[sw_ff[VOX_W-1:0]] <= '0;
      else if (cmd.mem_wr) vox_mem[vi] <= vox_wd;
      if (cmd.mem_rd) vox_rd_ff <= vox_mem[vi];
   end
   always_ff @(posedge clock) begin
      if (cmd.sweep) begin
         if (sw_ff < (VOX_W+1)'(NCELLS)) cell_mem[sw_ff[CELL_W-1:0]] <= '0;
      end else if (cmd.mem_wr) cell_mem[cell_addr] <= cell_wd;
      if (cmd.mem_rd) cell_rd_ff <= cell_mem[cell_addr];
   end
   always_ff @(posedge clock) begin
      if (reset || cmd.sweep) vcnt_ff <= '0;
      else if (cmd.mem_wr && !vox_rd_ff[20]) vcnt_ff <= vcnt_ff + 20'd1;
   end

   // result register
   logic strobe_ff;
   logic [CW-1:0] res_cell_ff;
   logic signed [3:0] oz_ff; logic signed [8:0] oy_ff, ox_ff;
   logic signed [19:0] on_ff;
   logic ins_ok;
   assign ins_ok = (mode_ff == MODE_INSERT) && !reject;
   always_ff @(posedge clock) begin
      if (reset) strobe_ff <= 1'b0;
      else strobe_ff <= cmd.emit;
      if (cmd.mem_wr) begin
         res_cell_ff <= cell_wd; on_ff <= num;
      end else if (cmd.mem_rd) begin
         res_cell_ff <= '0; on_ff <= '1;
      end
      if (cmd.emit) begin
         oz_ff <= ins_ok ? 4'(cz_ff) : '1;
         oy_ff <= ins_ok ? 9'(cy_ff) : '1;
         ox_ff <= ins_ok ? 9'(cx_ff) : '1;
      end
   end
   logic [CW-1:0] rc;
   logic rd_ok;
   assign rd_ok = (mode_ff == MODE_READ) && !reject;
   assign rc = ins_ok ? res_cell_ff : (rd_ok ? cell_rd_ff : '0);
   assign rsp_strobe = strobe_ff;
   assign rsp_coor_z = oz_ff;
   assign rsp_coor_y = oy_ff;
   assign rsp_coor_x = ox_ff;
   assign rsp_voxel_number = ins_ok ? on_ff : '1;
   assign {rsp_cell_max_height, rsp_cell_height_sum, rsp_cell_max_intensity,
      rsp_cell_intensity_sum, rsp_cell_point_count, rsp_cell_occupied,
      rsp_cell_height_bins} = rc;

   assign stat.sweep_done = sweep_done;
   assign stat.div_done = div_done;
   assign stat.mode = mode_ff;
   assign stat.reject = reject;
endmodule

@@ rtl/core/point_cloud_bev_voxelizer.sv @@
// point cloud bird's-eye voxelizer
// request channel: a word is taken when start is high and busy is low;
//   req_mode selects insert point, read one cell, or clear all stores
// response channel: one word per request, valid for a single cycle on
//   rsp_strobe; the receiver cannot stall, so nothing is held back
// csr channel: csr_valid/csr_ready write one of six grid registers;
//   csr_ready is always high; user must do writes while the block is idle (not enforced)
// sequencing: one request at a time, the next one is taken
//   in the cycle the response is on the strobe
//   insert: 3 axis divisions on one shared restoring divider, then memory
//   read and write; a point outside the grid skips the memory access
//   read: a memory read with no division; mode three: no division or memory access
//   clear: a sweep over the voxel table, one entry a cycle (NVOX entries,
//   524288 at the default grid), which also clears the cell store; the
//   response follows the sweep through the output state
// reset: the same clearing sweep runs after reset, busy stays high
//   until it ends and no response is given; csr writes are still taken
module point_cloud_bev_voxelizer import pcbv_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [15:0] req_point_x,
   input  logic signed [15:0] req_point_y,
   input  logic signed [15:0] req_point_z,
   input  logic [7:0]         req_intensity,
   input  logic [7:0]         req_read_cell_y,
   input  logic [7:0]         req_read_cell_x,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [15:0]        csr_data,
   output logic               rsp_strobe,
   output logic signed [3:0]  rsp_coor_z,
   output logic signed [8:0]  rsp_coor_y,
   output logic signed [8:0]  rsp_coor_x,
   output logic signed [19:0] rsp_voxel_number,
   output logic signed [15:0] rsp_cell_max_height,
   output logic signed [31:0] rsp_cell_height_sum,
   output logic [7:0]         rsp_cell_max_intensity,
   output logic [23:0]        rsp_cell_intensity_sum,
   output logic [15:0]        rsp_cell_point_count,
   output logic               rsp_cell_occupied,
   output logic [9:0]         rsp_cell_height_bins
);
   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   // sequencer: sweep, divide per axis, read-modify-write, respond
   pcbv_ctrl u_ctrl (.clock, .reset, .start, .busy, .stat, .cmd);

   pcbv_dp u_dp (.clock, .reset, .cmd, .stat, .csr_valid, .csr_index, .csr_data,
      .req_mode, .req_point_x, .req_point_y, .req_point_z, .req_intensity,
      .req_read_cell_y, .req_read_cell_x, .rsp_strobe, .rsp_coor_z, .rsp_coor_y,
      .rsp_coor_x, .rsp_voxel_number, .rsp_cell_max_height, .rsp_cell_height_sum,
      .rsp_cell_max_intensity, .rsp_cell_intensity_sum, .rsp_cell_point_count,
      .rsp_cell_occupied, .rsp_cell_height_bins);

   // an emit command is always followed by a response
   a_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> rsp_strobe) else $error("response strobe missing");
   // memory is never written during the sweep
   a_sweep: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sweep && cmd.mem_wr)) else $error("write during sweep");
   // a taken request always leaves the idle state
   a_take: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy) else $error("request not taken");
endmodule
